[rtl/stip_pkg.sv]
// shared types and constants for the string to integer parser
// holds character codes, status codes, config and parse state structs
// no dependencies
package stip_pkg;

    localparam logic [7:0] C_CH_ZERO  = 8'h30;
    localparam logic [7:0] C_CH_UPA   = 8'h41;
    localparam logic [7:0] C_CH_LOWA  = 8'h61;
    localparam logic [7:0] C_CH_MINUS = 8'h2D;
    localparam logic [7:0] C_CH_PLUS  = 8'h2B;
    localparam logic [7:0] C_HEX_TEN  = 8'd10;

    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 72;

    typedef enum logic [1:0] {
        REG_RADIX_HEX    = 2'd0,
        REG_SIGNED_MODE  = 2'd1,
        REG_WIDTH_SELECT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } t_width;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FITS      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic   radix_hex;
        logic   signed_mode;
        t_width width_select;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] mag_neg;
        logic               negative;
        logic               in_prefix;
        logic               overflowed;
    } t_parse;

    localparam t_cfg C_CFG_RST = '{
        radix_hex:    1'b0,
        signed_mode:  1'b1,
        width_select: WIDTH_64
    };

    localparam t_parse C_PARSE_RST = '{
        mag:        '0,
        mag_neg:    '0,
        negative:   1'b0,
        in_prefix:  1'b1,
        overflowed: 1'b0
    };

endpackage

[rtl/stip_step.sv]
// next parse state for one character: sign prefix, digit decode, limit check
// keeps magnitude and its two's complement negation side by side
// depends on stip_pkg
module stip_step
    import stip_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_parse     i_cur,
    input  logic [7:0] i_char,
    output t_parse     o_nxt
);

    logic [7:0]         digit;
    logic [VALUE_W-1:0] limit;
    logic [VALUE_W+3:0] mul;
    logic [VALUE_W+4:0] cand;
    logic [VALUE_W-1:0] mul_neg;
    logic [VALUE_W-1:0] cand_neg;
    logic               over;
    logic               is_sign;

    always_comb begin
        if (i_cfg.radix_hex && (i_char >= C_CH_LOWA)) begin
            digit = i_char - C_CH_LOWA + C_HEX_TEN;
        end else if (i_cfg.radix_hex && (i_char >= C_CH_UPA)) begin
            digit = i_char - C_CH_UPA + C_HEX_TEN;
        end else begin
            digit = i_char - C_CH_ZERO;
        end
    end

    // type maximum, or magnitude of the type minimum when negative
    always_comb begin
        case (i_cfg.width_select)
            WIDTH_8:  limit = i_cfg.signed_mode ? 64'h80 : 64'hFF;
            WIDTH_16: limit = i_cfg.signed_mode ? 64'h8000 : 64'hFFFF;
            WIDTH_32: limit = i_cfg.signed_mode ? 64'h8000_0000 : 64'hFFFF_FFFF;
            WIDTH_64: limit = i_cfg.signed_mode ? 64'h8000_0000_0000_0000
                                                : 64'hFFFF_FFFF_FFFF_FFFF;
            default:  limit = '0;
        endcase
        if (i_cfg.signed_mode && !i_cur.negative) begin
            limit = limit - 64'd1;
        end
    end

    always_comb begin
        if (i_cfg.radix_hex) begin
            mul     = {i_cur.mag, 4'b0000};
            mul_neg = {i_cur.mag_neg[VALUE_W-5:0], 4'b0000};
        end else begin
            mul     = {1'b0, i_cur.mag, 3'b000} + {3'b000, i_cur.mag, 1'b0};
            mul_neg = {i_cur.mag_neg[VALUE_W-4:0], 3'b000}
                    + {i_cur.mag_neg[VALUE_W-2:0], 1'b0};
        end
        cand     = {1'b0, mul} + {{(VALUE_W-3){1'b0}}, digit};
        cand_neg = mul_neg - {{(VALUE_W-8){1'b0}}, digit};
        over     = cand > {5'b00000, limit};
    end

    assign is_sign = i_cur.in_prefix && i_cfg.signed_mode
                   && ((i_char == C_CH_MINUS) || (i_char == C_CH_PLUS));

    always_comb begin
        o_nxt = i_cur;
        if (is_sign) begin
            if (i_char == C_CH_MINUS) begin
                o_nxt.negative = !i_cur.negative;
            end
        end else begin
            o_nxt.in_prefix = 1'b0;
            if (!i_cur.overflowed) begin
                if (over) begin
                    o_nxt.overflowed = 1'b1;
                end else begin
                    o_nxt.mag     = cand[VALUE_W-1:0];
                    o_nxt.mag_neg = cand_neg;
                end
            end
        end
    end

endmodule

[rtl/string_to_integer_parser.sv]
// top level of the string to integer parser: input register, parse state,
// result register and configuration registers
// depends on stip_pkg and stip_step
//
// channel | dir | fields (low bit up)                  | accepted when
// s_axis  | in  | tdata: char_code[7:0]; tlast: last   | s_axis_tvalid & s_axis_tready
// m_axis  | out | tdata: value[63:0], status[65:64]    | m_axis_tvalid & m_axis_tready
// cfg     | in  | index[1:0], data[1:0]                | i_cfg_valid & o_cfg_ready
//
// one character per cycle; a last character passes input and result registers
// the digit step (multiply by base, add digit, limit compare) sets the cycle
// reset is synchronous: parse state clears, registers take their defaults
// a waiting result stalls only a last character; other characters keep flowing
module string_to_integer_parser
    import stip_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // char_code[7:0]
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // value[63:0], status[65:64], zero pad
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [1:0]       i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [7:0]         r_in_char;
    logic               r_in_last;
    t_parse             r_st;
    t_parse             w_nxt;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    t_status            r_out_status;
    logic [VALUE_W-1:0] n_out_value;
    t_status            n_out_status;
    logic               out_free;
    logic               proc;

    stip_step u_step (
        .i_cfg  (r_cfg),
        .i_cur  (r_st),
        .i_char (r_in_char),
        .o_nxt  (w_nxt)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || proc;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        if (w_nxt.overflowed) begin
            n_out_value  = '0;
            n_out_status = w_nxt.negative ? STATUS_UNDERFLOW : STATUS_OVERFLOW;
        end else begin
            n_out_value  = w_nxt.negative ? w_nxt.mag_neg : w_nxt.mag;
            n_out_status = STATUS_FITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= C_CFG_RST;
            r_in_valid  <= 1'b0;
            r_st        <= C_PARSE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_RADIX_HEX:    r_cfg.radix_hex    <= i_cfg_data[0];
                    REG_SIGNED_MODE:  r_cfg.signed_mode  <= i_cfg_data[0];
                    REG_WIDTH_SELECT: r_cfg.width_select <= t_width'(i_cfg_data);
                    default:          r_cfg              <= r_cfg;
                endcase
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc) begin
                r_st <= r_in_last ? C_PARSE_RST : w_nxt;
            end
            if (proc && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (proc && r_in_last) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-VALUE_W-STATUS_W){1'b0}}, r_out_status, r_out_value};

endmodule
